// ===== hw/rtl/tandem_line_departure_times_unit_assert.svh =====
// assertion macros for the tandem line departure times unit
// users name their clock clk and their reset arst_n; no other dependencies
`ifndef TANDEM_LINE_DEPARTURE_TIMES_UNIT_ASSERT_SVH
`define TANDEM_LINE_DEPARTURE_TIMES_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TLDT_ASSERT_SAME(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);
`define TLDT_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define TLDT_ASSERT_SAME(lbl, pre, post, msg)
`define TLDT_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== hw/rtl/tldt_pkg.sv =====
// types, register indexes and saturating time arithmetic for the departure times unit
// no dependencies
package tldt_pkg;

	localparam int TIME_W = 48;
	localparam int SVC_W  = 32;
	localparam int CNT_W  = 16;
	localparam int BUF_W  = 7;

	typedef logic [TIME_W-1:0] time_t;
	typedef logic [SVC_W-1:0]  svc_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [BUF_W-1:0]  buf_t;

	localparam time_t TIME_MAX = '1;
	localparam cnt_t  CNT_MAX  = '1;

	// register index, taken from paddr[2]
	localparam logic REG_FIRST_BUF  = 1'b0;
	localparam logic REG_SECOND_BUF = 1'b1;

	function automatic time_t sat_add(time_t a, svc_t b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + (TIME_W+1)'(b);
		return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
	endfunction

	function automatic time_t max_time(time_t a, time_t b);
		return (a > b) ? a : b;
	endfunction

endpackage

// ===== hw/rtl/tandem_line_departure_times_unit.sv =====
// departure times of a three-stage blocking production line, one job per transfer
// depends on tldt_pkg and tandem_line_departure_times_unit_assert.svh
// path: an input transfer loads the job register, and the job commits into the result register
// throughput: one job per cycle while the result stream is not stalled; the ring reads
// are issued on the input transfer and written when the job moves into the result register
// reset clears counters, last departures and valid flags; ring contents are not
// cleared and need no clearing pass, buffer sizes reset to 1
`include "tandem_line_departure_times_unit_assert.svh"

module tandem_line_departure_times_unit #(
	parameter int MAX_BUFFER = 128
) (
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // service_one, service_two, service_three
	input  logic         s_tuser,   // first_job
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [159:0] m_tdata,   // job_number, leave_one, leave_two, leave_three
	// configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int SLOT_W = (MAX_BUFFER > 2) ? $clog2(MAX_BUFFER) : 1;
	localparam int EB_W   = (SLOT_W > tldt_pkg::BUF_W) ? SLOT_W : tldt_pkg::BUF_W;
	localparam logic [EB_W-1:0]   EB_MAX   = EB_W'(MAX_BUFFER - 1);
	localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(MAX_BUFFER - 1);
	localparam logic [SLOT_W:0]   RING_LEN = (SLOT_W+1)'(MAX_BUFFER);

	// configuration registers
	tldt_pkg::buf_t first_buf_q, second_buf_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_buf_q  <= tldt_pkg::buf_t'(1);
			second_buf_q <= tldt_pkg::buf_t'(1);
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				tldt_pkg::REG_FIRST_BUF:  first_buf_q  <= pwdata[tldt_pkg::BUF_W-1:0];
				tldt_pkg::REG_SECOND_BUF: second_buf_q <= pwdata[tldt_pkg::BUF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			tldt_pkg::REG_FIRST_BUF:  prdata = 32'(first_buf_q);
			tldt_pkg::REG_SECOND_BUF: prdata = 32'(second_buf_q);
			default:                  prdata = '0;
		endcase
	end

	// effective buffer sizes: zero acts as one, large values clamp to one less than the ring length
	logic [EB_W-1:0] eb1, eb2;

	always_comb begin
		if (first_buf_q == '0)
			eb1 = EB_W'(1);
		else if (EB_W'(first_buf_q) > EB_MAX)
			eb1 = EB_MAX;
		else
			eb1 = EB_W'(first_buf_q);
		if (second_buf_q == '0)
			eb2 = EB_W'(1);
		else if (EB_W'(second_buf_q) > EB_MAX)
			eb2 = EB_MAX;
		else
			eb2 = EB_W'(second_buf_q);
	end

	// front end: job number, ring slot and read addresses at the input transfer
	logic                s_acc, commit;
	tldt_pkg::cnt_t      acc_cnt_q, job_in;
	logic [SLOT_W-1:0]   acc_slot_q, slot_in;
	logic [SLOT_W-1:0]   eb1_slot, eb2_slot;
	logic [SLOT_W:0]     addr2_w, addr3_w;
	logic [SLOT_W-1:0]   addr2, addr3;

	assign s_acc    = s_tvalid && s_tready;
	assign job_in   = s_tuser ? tldt_pkg::cnt_t'(1) :
		((acc_cnt_q == tldt_pkg::CNT_MAX) ? tldt_pkg::CNT_MAX : acc_cnt_q + 1'b1);
	assign slot_in  = s_tuser ? '0 : acc_slot_q;
	assign eb1_slot = eb1[SLOT_W-1:0];
	assign eb2_slot = eb2[SLOT_W-1:0];
	assign addr2_w  = (slot_in >= eb1_slot) ? {1'b0, slot_in} - {1'b0, eb1_slot}
		: {1'b0, slot_in} + RING_LEN - {1'b0, eb1_slot};
	assign addr3_w  = (slot_in >= eb2_slot) ? {1'b0, slot_in} - {1'b0, eb2_slot}
		: {1'b0, slot_in} + RING_LEN - {1'b0, eb2_slot};
	assign addr2    = addr2_w[SLOT_W-1:0];
	assign addr3    = addr3_w[SLOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_cnt_q  <= '0;
			acc_slot_q <= '0;
		end else if (s_acc) begin
			acc_cnt_q  <= job_in;
			acc_slot_q <= (slot_in == SLOT_TOP) ? '0 : slot_in + 1'b1;
		end
	end

	// job register
	logic                s1_valid_q;
	logic                first_s1, early1_s1, early2_s1, byp1_s1, byp2_s1;
	tldt_pkg::cnt_t      job_s1;
	logic [SLOT_W-1:0]   slot_s1;
	tldt_pkg::svc_t      t1_s1, t2_s1, t3_s1;
	tldt_pkg::time_t     rd2_s1, rd3_s1;

	assign s_tready = !s1_valid_q || commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (s_acc)
			s1_valid_q <= 1'b1;
		else if (commit)
			s1_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			first_s1  <= s_tuser;
			job_s1    <= job_in;
			slot_s1   <= slot_in;
			early1_s1 <= job_in <= tldt_pkg::cnt_t'(eb1);
			early2_s1 <= job_in <= tldt_pkg::cnt_t'(eb2);
			// a buffer of one reads the job just before, still held in the last departures
			byp1_s1   <= eb1 == EB_W'(1);
			byp2_s1   <= eb2 == EB_W'(1);
			t1_s1     <= s_tdata[31:0];
			t2_s1     <= s_tdata[63:32];
			t3_s1     <= s_tdata[95:64];
		end
	end

	// history rings of stage two and stage three departures
	tldt_pkg::time_t ring2_mem [MAX_BUFFER];
	tldt_pkg::time_t ring3_mem [MAX_BUFFER];
	tldt_pkg::time_t d1, d2, d3;

	always_ff @(posedge clk) begin
		if (commit) begin
			ring2_mem[slot_s1] <= d2;
			ring3_mem[slot_s1] <= d3;
		end
		if (s_acc) begin
			rd2_s1 <= ring2_mem[addr2];
			rd3_s1 <= ring3_mem[addr3];
		end
	end

	// departure recursion
	tldt_pkg::time_t prev1_q, prev2_q, prev3_q;
	tldt_pkg::time_t p1, p2, p3, blk2, blk3;

	always_comb begin
		p1   = first_s1 ? '0 : prev1_q;
		p2   = first_s1 ? '0 : prev2_q;
		p3   = first_s1 ? '0 : prev3_q;
		blk2 = early1_s1 ? '0 : (byp1_s1 ? prev2_q : rd2_s1);
		blk3 = early2_s1 ? '0 : (byp2_s1 ? prev3_q : rd3_s1);
		d1   = tldt_pkg::max_time(tldt_pkg::sat_add(p1, t1_s1), blk2);
		d2   = tldt_pkg::max_time(tldt_pkg::sat_add(tldt_pkg::max_time(p2, d1), t2_s1), blk3);
		d3   = tldt_pkg::sat_add(tldt_pkg::max_time(p3, d2), t3_s1);
	end

	assign commit = s1_valid_q && (!m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev1_q <= '0;
			prev2_q <= '0;
			prev3_q <= '0;
		end else if (commit) begin
			prev1_q <= d1;
			prev2_q <= d2;
			prev3_q <= d3;
		end
	end

	// result register
	logic out_valid_q;
	logic [159:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (commit)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (commit)
			out_data_q <= {d3, d2, d1, job_s1};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`TLDT_ASSERT_SAME(a_order, m_tvalid,
		(m_tdata[159:112] >= m_tdata[111:64]) && (m_tdata[111:64] >= m_tdata[63:16]),
		"departures out of stage order")
	`TLDT_ASSERT_SAME(a_slot_range, 1'b1, acc_slot_q <= SLOT_TOP, "ring slot beyond ring")
	`TLDT_ASSERT_NEXT(a_prev_mono, commit && !first_s1, prev1_q >= $past(prev1_q),
		"stage one departure went back")
	`TLDT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

endmodule
